>>> rtl/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types, constants and lookup tables for the UTF-8 stream decoder:
// byte class map, automaton transition table and the step result struct.
// ----------------------------------------------------------------------------
package u8sd_pkg;

   localparam int STATE_BITS     = 4;
   localparam int CLASS_BITS     = 4;
   localparam int ACC_BITS       = 21;
   localparam int CHAR_CNT_BITS  = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int NUM_STATES     = 9;
   localparam int TABLE_DEPTH    = NUM_STATES * (2 ** CLASS_BITS);
   localparam int TABLE_IDX_BITS = STATE_BITS + CLASS_BITS;

   typedef logic [STATE_BITS-1:0] dfa_state_type;
   typedef logic [CLASS_BITS-1:0] byte_class_type;
   typedef logic [ACC_BITS-1:0]   code_type;

   // automaton states with a fixed meaning; the rest wait for continuation bytes
   localparam dfa_state_type ST_ACCEPT = 4'd0;
   localparam dfa_state_type ST_REJECT = 4'd1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_REJECT = 2'd1,
      STATUS_MORE   = 2'd2
   } status_type;

   // one decoding step, handed from the step logic to the top level
   typedef struct packed {
      dfa_state_type next_state;
      code_type      accum;
   } step_type;

   // next state, indexed by {state, class}; one row of 16 classes per state
   localparam dfa_state_type NEXT_STATE_TABLE [TABLE_DEPTH] = '{
      4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1
   };

   // byte class map
   function automatic byte_class_type byte_class(input logic [7:0] b);
      byte_class_type cls;
      case (b) inside
         [8'h00:8'h7F]: cls = 4'd0;
         [8'h80:8'h8F]: cls = 4'd1;
         [8'h90:8'h9F]: cls = 4'd9;
         [8'hA0:8'hBF]: cls = 4'd7;
         [8'hC0:8'hC1]: cls = 4'd8;
         [8'hC2:8'hDF]: cls = 4'd2;
         8'hE0:         cls = 4'd10;
         [8'hE1:8'hEC]: cls = 4'd3;
         8'hED:         cls = 4'd4;
         [8'hEE:8'hEF]: cls = 4'd3;
         8'hF0:         cls = 4'd11;
         [8'hF1:8'hF3]: cls = 4'd6;
         8'hF4:         cls = 4'd5;
         default:       cls = 4'd8;
      endcase
      return cls;
   endfunction

   // transition lookup; an out-of-range state behaves as reject
   function automatic dfa_state_type next_state(input dfa_state_type st,
                                                input byte_class_type cls);
      dfa_state_type               st_ok;
      logic [TABLE_IDX_BITS-1:0]   idx;
      st_ok = (st >= dfa_state_type'(NUM_STATES)) ? ST_REJECT : st;
      idx   = {st_ok, cls};
      return NEXT_STATE_TABLE[idx];
   endfunction

endpackage

>>> rtl/u8sd_step.sv
// ----------------------------------------------------------------------------
// u8sd_step
// One decoding step: classify the byte, advance the automaton and fold the
// payload bits into the code point accumulator. Pure combinational logic.
// ----------------------------------------------------------------------------
module u8sd_step (
   input  u8sd_pkg::dfa_state_type state,
   input  u8sd_pkg::code_type      accum,
   input  logic [7:0]              data_byte,
   output u8sd_pkg::step_type      step
);

   u8sd_pkg::byte_class_type cls;
   logic                     in_accept;
   logic [7:0]               lead_bits;

   // byte class, transition and accumulator update
   always_comb begin
      cls       = u8sd_pkg::byte_class(data_byte);
      in_accept = (state == u8sd_pkg::ST_ACCEPT);
      lead_bits = (8'hFF >> cls) & data_byte;
      step.next_state = u8sd_pkg::next_state(state, cls);
      // lead byte loads its payload bits, continuation bytes shift in six more
      if (in_accept) begin
         step.accum = u8sd_pkg::code_type'(lead_bits);
      end else begin
         step.accum = {accum[u8sd_pkg::ACC_BITS-7:0], data_byte[5:0]};
      end
   end

endmodule

>>> rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Table-driven UTF-8 decoder and validator with a per-string character count.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and returns one result per byte,
// in the cycle after the byte is accepted. The byte class lookup, the
// transition table and the accumulator shift all sit between the state
// registers and the result register, so a new byte can follow every cycle;
// the result register passes ready straight through, so it keeps that rate
// whenever the downstream side takes results as fast. Status 0 means a
// character completed (code point valid), 1 means the string is rejected
// (sticky until the byte flagged last), 2 means more bytes are needed. The
// byte flagged last reports string_ok and clears the automaton and counter.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
   parameter int COUNT_BITS = u8sd_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_string,
   // decode result
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [20:0] rsp_code_point,
   output logic [15:0] rsp_char_count,
   output logic        rsp_string_ok,
   output logic        rsp_last_out
);

   localparam int CNT_VIEW = (COUNT_BITS < u8sd_pkg::CHAR_CNT_BITS) ?
                             COUNT_BITS : u8sd_pkg::CHAR_CNT_BITS;

   u8sd_pkg::dfa_state_type dfa_state_ff, dfa_state_in;
   u8sd_pkg::code_type      code_accum_ff, code_accum_in;
   logic [COUNT_BITS-1:0]   char_counter_ff, char_counter_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   u8sd_pkg::status_type    status_ff, status_in;
   u8sd_pkg::code_type      code_point_ff, code_point_in;
   logic [15:0]             char_count_ff, char_count_in;
   logic                    string_ok_ff, string_ok_in;
   logic                    last_out_ff, last_out_in;

   u8sd_pkg::step_type      step;
   logic                    req_accept;
   logic                    done;
   logic [COUNT_BITS-1:0]   counter_next;

   u8sd_step u_step (
      .state     (dfa_state_ff),
      .accum     (code_accum_ff),
      .data_byte (req_data_byte),
      .step      (step)
   );

   // handshake: result register frees up when empty or being drained
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // character completion and saturating count
   always_comb begin
      done         = (step.next_state == u8sd_pkg::ST_ACCEPT);
      counter_next = char_counter_ff;
      if (done && (char_counter_ff != {COUNT_BITS{1'b1}})) begin
         counter_next = char_counter_ff + 1'b1;
      end
   end

   // next values of state and result registers
   always_comb begin
      dfa_state_in    = dfa_state_ff;
      code_accum_in   = code_accum_ff;
      char_counter_in = char_counter_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      status_in       = status_ff;
      code_point_in   = code_point_ff;
      char_count_in   = char_count_ff;
      string_ok_in    = string_ok_ff;
      last_out_in     = last_out_ff;
      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         if (done) begin
            status_in = u8sd_pkg::STATUS_DONE;
         end else if (step.next_state == u8sd_pkg::ST_REJECT) begin
            status_in = u8sd_pkg::STATUS_REJECT;
         end else begin
            status_in = u8sd_pkg::STATUS_MORE;
         end
         code_point_in = done ? step.accum : '0;
         char_count_in = 16'(counter_next[CNT_VIEW-1:0]);
         string_ok_in  = req_end_of_string && done;
         last_out_in   = req_end_of_string;
         if (req_end_of_string) begin
            dfa_state_in    = u8sd_pkg::ST_ACCEPT;
            code_accum_in   = '0;
            char_counter_in = '0;
         end else begin
            dfa_state_in    = step.next_state;
            code_accum_in   = step.accum;
            char_counter_in = counter_next;
         end
      end
   end

   // control and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         dfa_state_ff    <= u8sd_pkg::ST_ACCEPT;
         code_accum_ff   <= '0;
         char_counter_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         dfa_state_ff    <= dfa_state_in;
         code_accum_ff   <= code_accum_in;
         char_counter_ff <= char_counter_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      code_point_ff <= code_point_in;
      char_count_ff <= char_count_in;
      string_ok_ff  <= string_ok_in;
      last_out_ff   <= last_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_code_point = code_point_ff;
   assign rsp_char_count = char_count_ff;
   assign rsp_string_ok  = string_ok_ff;
   assign rsp_last_out   = last_out_ff;

   // code point only shown with a completed character
   a_cp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != u8sd_pkg::STATUS_DONE) |-> code_point_ff == '0)
      else $error("code point nonzero without a completed character");

   // string_ok only on the last byte of an accepted string
   a_ok_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && string_ok_ff |-> last_out_ff && (status_ff == u8sd_pkg::STATUS_DONE))
      else $error("string_ok without last byte in accept");

   // last byte clears the automaton and the counter
   a_eos_clear: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_end_of_string |=>
         (dfa_state_ff == u8sd_pkg::ST_ACCEPT) && (char_counter_ff == '0))
      else $error("state not cleared after last byte");

   // reject holds until the string ends
   a_reject_sticky: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_end_of_string && (dfa_state_ff == u8sd_pkg::ST_REJECT) |=>
         dfa_state_ff == u8sd_pkg::ST_REJECT)
      else $error("reject state left before end of string");

   // automaton never leaves its defined range
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      dfa_state_ff < u8sd_pkg::dfa_state_type'(u8sd_pkg::NUM_STATES))
      else $error("automaton state out of range");

endmodule
